// File: rtl/core/fdnr_pkg.sv
package fdnr_pkg;

   // Line geometry.
   localparam int DELAY_LENGTH = 512;
   localparam int POS_WIDTH    = (DELAY_LENGTH > 1) ? $clog2(DELAY_LENGTH) : 1;
   localparam int NUM_LINES    = 4;

   // Field and datapath widths.
   localparam int SAMPLE_WIDTH = 16;
   localparam int GAIN_WIDTH   = 16;
   localparam int STORE_WIDTH  = 24;
   localparam int ENTRY_WIDTH  = NUM_LINES * STORE_WIDTH;
   localparam int U_WIDTH      = 18;
   localparam int SUM_WIDTH    = 25;
   localparam int MIX_WIDTH    = 27;
   localparam int PROD_WIDTH   = GAIN_WIDTH + 1 + MIX_WIDTH;

   // Register file.
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INPUT_GAIN      = 3'd0,
      CSR_OUTPUT_GAIN     = 3'd1,
      CSR_FEEDBACK_GAIN_0 = 3'd2,
      CSR_FEEDBACK_GAIN_1 = 3'd3,
      CSR_FEEDBACK_GAIN_2 = 3'd4,
      CSR_FEEDBACK_GAIN_3 = 3'd5
   } csr_index_type;

   localparam logic [GAIN_WIDTH-1:0] INPUT_GAIN_RESET    = 16'd8192;
   localparam logic [GAIN_WIDTH-1:0] OUTPUT_GAIN_RESET   = 16'd32768;
   localparam logic [GAIN_WIDTH-1:0] FEEDBACK_GAIN_RESET = 16'd26214;

   // Hadamard signs: bit [row][col] set means that column is subtracted.
   localparam logic [NUM_LINES-1:0][NUM_LINES-1:0] MIX_NEG = {
      4'b0110, 4'b0011, 4'b0101, 4'b0000
   };

   typedef struct packed {
      logic [GAIN_WIDTH-1:0]                input_gain;
      logic [GAIN_WIDTH-1:0]                output_gain;
      logic [NUM_LINES-1:0][GAIN_WIDTH-1:0] feedback_gain;
   } gains_type;

   typedef struct packed {
      logic                 en;
      logic [POS_WIDTH-1:0] addr;
   } wr_type;

   // Positions of the requests that have read but not yet written back.
   typedef struct packed {
      logic [2:0]                busy;
      logic [2:0][POS_WIDTH-1:0] pos;
   } hazard_type;

   typedef struct packed {
      logic                    valid;
      logic [SAMPLE_WIDTH-1:0] sample;
      logic                    clipped;
   } result_type;

endpackage

// File: rtl/core/fdnr_req_if.sv
interface fdnr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [fdnr_pkg::SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

// File: rtl/core/fdnr_rsp_if.sv
interface fdnr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [fdnr_pkg::SAMPLE_WIDTH-1:0] sample_out;
   logic                                   clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

// File: rtl/core/fdnr_delay_ram.sv
module fdnr_delay_ram (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic [fdnr_pkg::POS_WIDTH-1:0]   rd_addr,
   output logic [fdnr_pkg::ENTRY_WIDTH-1:0] rd_data,
   input  fdnr_pkg::wr_type                 wr,
   input  logic [fdnr_pkg::ENTRY_WIDTH-1:0] wr_data
);
   import fdnr_pkg::*;

   logic [ENTRY_WIDTH-1:0] store_ff [DELAY_LENGTH];
   logic [ENTRY_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr] <= wr_data;
      end
   end

   // Read port; a write to the same entry in the same cycle is passed through.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= store_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/fdnr_datapath.sv
module fdnr_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic                                    accept,
   input  logic signed [fdnr_pkg::SAMPLE_WIDTH-1:0] sample_in,
   input  logic [fdnr_pkg::POS_WIDTH-1:0]          pos,
   input  logic                                    fresh,
   input  logic [fdnr_pkg::ENTRY_WIDTH-1:0]        rd_data,
   input  fdnr_pkg::gains_type                     gains,
   output fdnr_pkg::wr_type                        wr,
   output logic [fdnr_pkg::ENTRY_WIDTH-1:0]        wr_data,
   output fdnr_pkg::hazard_type                    hazard,
   output fdnr_pkg::result_type                    result
);
   import fdnr_pkg::*;

   // Stage A: scaled input, issued together with the memory read.
   logic signed [SAMPLE_WIDTH+GAIN_WIDTH:0] u_prod;
   logic signed [SAMPLE_WIDTH+GAIN_WIDTH:0] u_round;
   logic                                    a_valid_ff, a_valid_in;
   logic signed [U_WIDTH-1:0]               a_u_ff, a_u_in;
   logic [POS_WIDTH-1:0]                    a_pos_ff;
   logic                                    a_fresh_ff;

   // Stage B: per-line sums.
   logic                                    b_valid_ff;
   logic [NUM_LINES-1:0][SUM_WIDTH-1:0]     b_s_ff, b_s_in;
   logic [POS_WIDTH-1:0]                    b_pos_ff;

   // Stage C: total and mixed values.
   logic                                    c_valid_ff;
   logic signed [MIX_WIDTH-1:0]             c_total_ff, c_total_in;
   logic [NUM_LINES-1:0][MIX_WIDTH-1:0]     c_m_ff, c_m_in;
   logic [POS_WIDTH-1:0]                    c_pos_ff;

   // Stage D: gain products.
   logic                                    d_valid_ff;
   logic signed [PROD_WIDTH-1:0]            d_py_ff, d_py_in;
   logic [NUM_LINES-1:0][PROD_WIDTH-1:0]    d_pw_ff, d_pw_in;
   logic [POS_WIDTH-1:0]                    d_pos_ff;

   // Output rounding and saturation.
   logic signed [PROD_WIDTH-1:0]            y_round;
   logic [PROD_WIDTH-16:0]                  y_wide;
   logic                                    y_clip;

   // Input gain, rounded half up at bit 15.
   assign u_prod     = $signed({1'b0, gains.input_gain}) * sample_in;
   assign u_round    = u_prod + (SAMPLE_WIDTH+GAIN_WIDTH+1)'(16384);
   assign a_u_in     = u_round[15 +: U_WIDTH];
   assign a_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   // Line sums; lines not yet written in the first pass read as zero.
   always_comb begin
      logic signed [STORE_WIDTH-1:0] d_val;
      for (int i = 0; i < NUM_LINES; i++) begin
         d_val     = a_fresh_ff ? '0 : $signed(rd_data[i*STORE_WIDTH +: STORE_WIDTH]);
         b_s_in[i] = SUM_WIDTH'(a_u_ff) + SUM_WIDTH'(d_val);
      end
   end

   // Total for the output and the Hadamard mix for the feedback.
   always_comb begin
      logic signed [MIX_WIDTH-1:0] term;
      logic signed [MIX_WIDTH-1:0] acc;
      c_total_in = '0;
      for (int j = 0; j < NUM_LINES; j++) begin
         c_total_in = c_total_in + MIX_WIDTH'($signed(b_s_ff[j]));
      end
      for (int i = 0; i < NUM_LINES; i++) begin
         acc = '0;
         for (int j = 0; j < NUM_LINES; j++) begin
            term = MIX_WIDTH'($signed(b_s_ff[j]));
            if (MIX_NEG[i][j]) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
         c_m_in[i] = acc;
      end
   end

   // Gain multipliers, one per lane.
   always_comb begin
      d_py_in = $signed({1'b0, gains.output_gain}) * c_total_ff;
      for (int i = 0; i < NUM_LINES; i++) begin
         d_pw_in[i] = $signed({1'b0, gains.feedback_gain[i]}) * $signed(c_m_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_u_ff     <= a_u_in;
         a_pos_ff   <= pos;
         a_fresh_ff <= fresh;
         b_s_ff     <= b_s_in;
         b_pos_ff   <= a_pos_ff;
         c_total_ff <= c_total_in;
         c_m_ff     <= c_m_in;
         c_pos_ff   <= b_pos_ff;
         d_py_ff    <= d_py_in;
         d_pw_ff    <= d_pw_in;
         d_pos_ff   <= c_pos_ff;
      end
   end

   // Output sample: round at bit 15, then saturate to 16 bits.
   assign y_round = d_py_ff + PROD_WIDTH'(16384);
   assign y_wide  = y_round[PROD_WIDTH-1:15];
   assign y_clip  = !((&y_wide[PROD_WIDTH-16:15]) || !(|y_wide[PROD_WIDTH-16:15]));

   always_comb begin
      result.valid   = d_valid_ff;
      result.clipped = y_clip;
      if (!y_clip) begin
         result.sample = y_wide[SAMPLE_WIDTH-1:0];
      end else if (y_wide[PROD_WIDTH-16]) begin
         result.sample = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         result.sample = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
   end

   // Write-back: round at bit 16 and saturate to the stored width.
   always_comb begin
      logic signed [PROD_WIDTH-1:0] w_round;
      logic [PROD_WIDTH-17:0]       w_wide;
      logic                         w_ok;
      for (int i = 0; i < NUM_LINES; i++) begin
         w_round = $signed(d_pw_ff[i]) + PROD_WIDTH'(32768);
         w_wide  = w_round[PROD_WIDTH-1:16];
         w_ok    = (&w_wide[PROD_WIDTH-17:STORE_WIDTH-1]) ||
                   !(|w_wide[PROD_WIDTH-17:STORE_WIDTH-1]);
         if (w_ok) begin
            wr_data[i*STORE_WIDTH +: STORE_WIDTH] = w_wide[STORE_WIDTH-1:0];
         end else if (w_wide[PROD_WIDTH-17]) begin
            wr_data[i*STORE_WIDTH +: STORE_WIDTH] = {1'b1, {(STORE_WIDTH-1){1'b0}}};
         end else begin
            wr_data[i*STORE_WIDTH +: STORE_WIDTH] = {1'b0, {(STORE_WIDTH-1){1'b1}}};
         end
      end
   end

   assign wr.en   = d_valid_ff && advance;
   assign wr.addr = d_pos_ff;

   // Requests between the read and the write-back.
   assign hazard.busy = {c_valid_ff, b_valid_ff, a_valid_ff};
   assign hazard.pos  = {c_pos_ff, b_pos_ff, a_pos_ff};

endmodule

// File: rtl/core/fdn_reverb_four_line_unit.sv
// A request accepted passes the memory read and three arithmetic stages
// before its response is registered. Throughput: one request per cycle while
// responses are taken, set by the single read and write port of the delay
// memory; lines shorter than four entries add an interlock stall.
// Reset: the gains return to their defaults, the position to zero and the
// pipeline empties; the delay memory is not swept and reads as zero until the
// position first wraps, so the block takes requests right after reset.
module fdn_reverb_four_line_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   fdnr_req_if.sink                             req,
   fdnr_rsp_if.source                           rsp,
   input  logic                                 csr_wr_en,
   input  logic [fdnr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fdnr_pkg::GAIN_WIDTH-1:0]      csr_wr_data
);
   import fdnr_pkg::*;

   localparam logic [POS_WIDTH-1:0] LAST_POS = POS_WIDTH'(DELAY_LENGTH - 1);

   gains_type              gains_ff, gains_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic                   wrapped_ff, wrapped_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                   rsp_clipped_ff;

   logic                   advance;
   logic                   hazard_hit;
   logic                   accept;
   logic [ENTRY_WIDTH-1:0] rd_data;
   logic [ENTRY_WIDTH-1:0] wr_data;
   wr_type                 wr;
   hazard_type             hazard;
   result_type             result;

   // Register writes.
   always_comb begin
      gains_in = gains_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_INPUT_GAIN:      gains_in.input_gain       = csr_wr_data;
            CSR_OUTPUT_GAIN:     gains_in.output_gain      = csr_wr_data;
            CSR_FEEDBACK_GAIN_0: gains_in.feedback_gain[0] = csr_wr_data;
            CSR_FEEDBACK_GAIN_1: gains_in.feedback_gain[1] = csr_wr_data;
            CSR_FEEDBACK_GAIN_2: gains_in.feedback_gain[2] = csr_wr_data;
            CSR_FEEDBACK_GAIN_3: gains_in.feedback_gain[3] = csr_wr_data;
            default:             gains_in = gains_ff;
         endcase
      end
   end

   // The pipeline moves when the response register is free or being emptied.
   assign advance = !rsp_valid_ff || rsp.ready;

   // Hold a request whose entry is still waiting for an earlier write-back.
   always_comb begin
      hazard_hit = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (hazard.busy[k] && (hazard.pos[k] == pos_ff)) begin
            hazard_hit = 1'b1;
         end
      end
   end

   assign req.ready = advance && !hazard_hit;
   assign accept    = req.valid && req.ready;

   // Shared line position and the first-pass marker.
   always_comb begin
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         if (pos_ff == LAST_POS) begin
            pos_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            pos_in = pos_ff + POS_WIDTH'(1);
         end
      end
   end

   assign rsp_valid_in = advance ? result.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.input_gain    <= INPUT_GAIN_RESET;
         gains_ff.output_gain   <= OUTPUT_GAIN_RESET;
         gains_ff.feedback_gain <= {NUM_LINES{FEEDBACK_GAIN_RESET}};
         pos_ff                 <= '0;
         wrapped_ff             <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         gains_ff     <= gains_in;
         pos_ff       <= pos_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         rsp_sample_ff  <= result.sample;
         rsp_clipped_ff <= result.clipped;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = rsp_sample_ff;
   assign rsp.clipped    = rsp_clipped_ff;

   fdnr_delay_ram u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (rd_data),
      .wr      (wr),
      .wr_data (wr_data)
   );

   fdnr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .accept    (accept),
      .sample_in (req.sample_in),
      .pos       (pos_ff),
      .fresh     (!wrapped_ff),
      .rd_data   (rd_data),
      .gains     (gains_ff),
      .wr        (wr),
      .wr_data   (wr_data),
      .hazard    (hazard),
      .result    (result)
   );

endmodule
